FILE: rtl/gshc_pkg.sv
// ----------------------------------------------------------------------------
// gshc_pkg
// Types, tables and constants shared by the Gregorian / Solar Hijri date
// converter.
// ----------------------------------------------------------------------------
package gshc_pkg;

  // Direction codes carried in the kind field.
  localparam logic KIND_G2S = 1'b0;
  localparam logic KIND_S2G = 1'b1;

  // Reciprocal of 100 for the year reduction: floor(x / 100) equals
  // (x * 1311) >> 17 for every 12-bit x.
  localparam int unsigned  DIV100_SHIFT = 17;
  localparam logic [10:0]  DIV100_MUL   = 11'd1311;
  localparam logic [6:0]   CENTURY      = 7'd100;

  // Year offsets.
  localparam logic [7:0]   G2S_OFS_PRE  = 8'd78;
  localparam logic [7:0]   G2S_OFS_POST = 8'd79;
  localparam logic [7:0]   G2S_WRAP     = 8'd50;
  localparam logic [11:0]  G2S_BASE_LO  = 12'd1300;
  localparam logic [11:0]  G2S_BASE_HI  = 12'd1400;
  localparam logic [6:0]   S2G_OFS_PRE  = 7'd79;
  localparam logic [6:0]   S2G_OFS_POST = 7'd78;
  localparam logic [6:0]   S2G_WRAP     = 7'd70;
  localparam logic [11:0]  S2G_BASE_LO  = 12'd1900;
  localparam logic [11:0]  S2G_BASE_HI  = 12'd2000;

  // Month numbers that decide the year change.
  localparam logic [3:0]   MONTH_MAR    = 4'd3;
  localparam logic [3:0]   MONTH_DEY    = 4'd10;
  localparam logic [3:0]   MONTH_LAST   = 4'd12;
  localparam logic [4:0]   DAY_MAX      = 5'd31;

  // Day-offset tables, indexed [row][month - 1].
  localparam logic [4:0] SH_TAB [6][12] = '{
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd9},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd10},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10, 5'd11, 5'd12, 5'd10},
    '{5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd19, 5'd18}
  };

  localparam logic [4:0] GR_TAB [6][12] = '{
    '{5'd20, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20},
    '{5'd10, 5'd11, 5'd10, 5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10},
    '{5'd19, 5'd18, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd11, 5'd12, 5'd10, 5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9},
    '{5'd20, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd10, 5'd11, 5'd9,  5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9}
  };

  // One source date.
  typedef struct packed {
    logic        kind;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [2:0]  weekday_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } req_t;

  // One converted date.
  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } rsp_t;

endpackage

FILE: rtl/gshc_req_if.sv
// ----------------------------------------------------------------------------
// gshc_req_if
// Valid/ready channel that carries one source date per beat.
// ----------------------------------------------------------------------------
interface gshc_req_if
  import gshc_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gshc_rsp_if.sv
// ----------------------------------------------------------------------------
// gshc_rsp_if
// Valid/ready channel that carries one converted date per beat.
// ----------------------------------------------------------------------------
interface gshc_rsp_if
  import gshc_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gshc_conv.sv
// ----------------------------------------------------------------------------
// gshc_conv
// Combinational date conversion between Gregorian and Solar Hijri by
// table lookup.
// ----------------------------------------------------------------------------
module gshc_conv
  import gshc_pkg::*;
(
  input  req_t req,
  output rsp_t rsp
);

  logic [22:0] prod;
  logic [5:0]  quot;
  logic [12:0] quot_x100;
  logic [6:0]  yr;
  logic [2:0]  row;
  logic [3:0]  col;
  logic [4:0]  t1;
  logic [4:0]  t2;
  logic        day_le;
  logic        pre;
  logic [7:0]  g_short;
  logic [6:0]  s_ofs;
  logic [6:0]  s_short;
  logic [11:0] year_full;
  logic [4:0]  month_sum;
  logic [4:0]  month_mod;
  logic [5:0]  day_sum;
  logic [4:0]  day_res;

  // Reduce the year modulo 100 with a reciprocal multiply.
  assign prod      = req.year_in * DIV100_MUL;
  assign quot      = prod[22:DIV100_SHIFT];
  assign quot_x100 = quot * CENTURY;
  assign yr        = 7'(req.year_in - quot_x100[11:0]);

  // Table row pair from the year modulo 4, column from the month.
  always_comb begin
    if (req.kind == KIND_G2S) begin
      case (yr[1:0])
        2'd0:    row = 3'd0;
        2'd1:    row = 3'd2;
        default: row = 3'd4;
      endcase
    end else begin
      case (yr[1:0])
        2'd2:    row = 3'd2;
        2'd3:    row = 3'd4;
        default: row = 3'd0;
      endcase
    end
    if (req.month_in >= 4'd1 && req.month_in <= MONTH_LAST) begin
      col = req.month_in - 4'd1;
    end else begin
      col = 4'd11;
    end
  end

  // Table entries for the selected row pair and column.
  always_comb begin
    if (req.kind == KIND_G2S) begin
      t1 = GR_TAB[row][col];
      t2 = GR_TAB[row + 3'd1][col];
    end else begin
      t1 = SH_TAB[row][col];
      t2 = SH_TAB[row + 3'd1][col];
    end
    day_le = (req.day_in <= t1);
  end

  // Target year: a fixed offset from the reduced year, then the century.
  always_comb begin
    g_short = 8'd0;
    s_ofs   = 7'd0;
    s_short = 7'd0;
    if (req.kind == KIND_G2S) begin
      pre     = (req.month_in < MONTH_MAR) || (req.month_in == MONTH_MAR && day_le);
      g_short = {1'b0, yr} + (pre ? G2S_OFS_PRE : G2S_OFS_POST);
      year_full = {4'd0, g_short} + ((g_short < G2S_WRAP) ? G2S_BASE_HI : G2S_BASE_LO);
    end else begin
      pre   = (req.month_in < MONTH_DEY) || (req.month_in == MONTH_DEY && day_le);
      s_ofs = pre ? S2G_OFS_PRE : S2G_OFS_POST;
      if (yr >= s_ofs) begin
        s_short = yr - s_ofs;
      end else begin
        s_short = yr + (CENTURY - s_ofs);
      end
      year_full = {5'd0, s_short} + ((s_short < S2G_WRAP) ? S2G_BASE_HI : S2G_BASE_LO);
    end
  end

  // Target month: shift by 8 or 9 (G2S) or 1 or 2 (S2G), wrapped over twelve.
  always_comb begin
    if (req.kind == KIND_G2S) begin
      month_sum = {1'b0, req.month_in} + (day_le ? 5'd8 : 5'd9);
    end else begin
      month_sum = {1'b0, req.month_in} + (day_le ? 5'd1 : 5'd2);
    end
    if (month_sum >= 5'd24) begin
      month_mod = month_sum - 5'd24;
    end else if (month_sum >= 5'd12) begin
      month_mod = month_sum - 5'd12;
    end else begin
      month_mod = month_sum;
    end
  end

  // Target day: carry into the next month or drop the offset, capped at 31.
  always_comb begin
    day_sum = {1'b0, req.day_in} + {1'b0, t2};
    if (day_le) begin
      day_res = (day_sum > {1'b0, DAY_MAX}) ? DAY_MAX : day_sum[4:0];
    end else begin
      day_res = req.day_in - t1;
    end
  end

  // Assemble the result; the time of day passes through.
  always_comb begin
    rsp.year_out    = year_full;
    rsp.month_out   = month_mod[3:0] + 4'd1;
    rsp.day_out     = day_res;
    rsp.weekday_out = req.weekday_in;
    rsp.hour_out    = req.hour_in;
    rsp.minute_out  = req.minute_in;
    rsp.second_out  = req.second_in;
  end

endmodule

FILE: rtl/gregorian_solar_hijri_convert_core.sv
// ----------------------------------------------------------------------------
// gregorian_solar_hijri_convert_core
// Gregorian / Solar Hijri date converter with valid/ready channels.
// ----------------------------------------------------------------------------
// Each beat on req carries one date and a direction; rsp returns the converted
// date via the input and result registers, weekday and time of day copied.
// It takes one date per clock unless rsp stalls: the two registers hold the
// two dates in flight, and the conversion (year modulo 100, one table lookup,
// a compare and a few adds) sits between them. A stall on rsp holds both
// registers; req stays ready while either register is free to advance.
// Results hold for Gregorian years 2000 to 2099 and matching Shamsi years.
module gregorian_solar_hijri_convert_core
  import gshc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  gshc_req_if.sink   req,
  gshc_rsp_if.source rsp
);

  logic in_valid;
  req_t in_data;
  logic out_valid;
  rsp_t out_data;
  rsp_t conv_rsp;
  logic out_load;
  logic in_load;

  // Pipeline advance: the result register frees when empty or taken.
  assign out_load  = !out_valid || rsp.ready;
  assign in_load   = !in_valid || out_load;
  assign req.ready = in_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= req.valid;
    end
    if (in_load && req.valid) begin
      in_data <= req.data;
    end
  end

  gshc_conv u_conv (
    .req (in_data),
    .rsp (conv_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      out_data <= conv_rsp;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

FILE: verif/gshc_date_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gshc_date_checker
// Watches the request and response channels of the date converter. For
// every accepted request beat it computes the converted date on its own,
// queues it, and compares each response beat field by field against the
// oldest queued date.
// ----------------------------------------------------------------------------
module gshc_date_checker
  import gshc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gshc_req_if  req,
  gshc_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  // Day offsets for the Gregorian to Shamsi direction, [row][month - 1].
  localparam logic [4:0] GREG_DAY_OFS [6][12] = '{
    '{5'd20, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20},
    '{5'd10, 5'd11, 5'd10, 5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10},
    '{5'd19, 5'd18, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd11, 5'd12, 5'd10, 5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9},
    '{5'd20, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd10, 5'd11, 5'd9,  5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9}
  };

  // Day offsets for the Shamsi to Gregorian direction, [row][month - 1].
  localparam logic [4:0] SHAMSI_DAY_OFS [6][12] = '{
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd9},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd10},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10, 5'd11, 5'd12, 5'd10},
    '{5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd19, 5'd18}
  };

  rsp_t converted_dates[$];

  // Converts one date the way the block is meant to.
  function automatic rsp_t convert_date(req_t src);
    int unsigned yy;
    int unsigned mm;
    int unsigned dd;
    int unsigned col;
    int unsigned row;
    int unsigned cut;
    int unsigned add;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    rsp_t        res;
    yy  = src.year_in % 100;
    mm  = src.month_in;
    dd  = src.day_in;
    // Months outside 1..12 fall back to the December column.
    col = (mm >= 1 && mm <= 12) ? mm - 1 : 11;
    if (src.kind == KIND_G2S) begin
      case (yy % 4)
        0:       row = 0;
        1:       row = 2;
        default: row = 4;
      endcase
      cut = GREG_DAY_OFS[row][col];
      add = GREG_DAY_OFS[row + 1][col];
      // Before Nowruz the Shamsi year is one lower.
      if (mm < 3 || (mm == 3 && dd <= cut)) yr = yy + 78;
      else yr = yy + 79;
      yr += (yr < 50) ? 1400 : 1300;
      if (dd <= cut) begin
        dy = dd + add;
        mo = (mm + 8) % 12 + 1;
      end else begin
        dy = dd - cut;
        mo = (mm + 9) % 12 + 1;
      end
    end else begin
      case (yy % 4)
        0, 1:    row = 0;
        2:       row = 2;
        default: row = 4;
      endcase
      cut = SHAMSI_DAY_OFS[row][col];
      add = SHAMSI_DAY_OFS[row + 1][col];
      // Before January 1 the Gregorian year is one lower.
      if (mm < 10 || (mm == 10 && dd <= cut)) yr = (yy >= 79) ? yy - 79 : yy + 21;
      else yr = (yy >= 78) ? yy - 78 : yy + 22;
      yr += (yr < 70) ? 2000 : 1900;
      if (dd <= cut) begin
        dy = dd + add;
        mo = (mm + 1) % 12 + 1;
      end else begin
        dy = dd - cut;
        mo = (mm + 2) % 12 + 1;
      end
    end
    if (dy > 31) dy = 31;
    res.year_out    = yr[11:0];
    res.month_out   = mo[3:0];
    res.day_out     = dy[4:0];
    res.weekday_out = src.weekday_in;
    res.hour_out    = src.hour_in;
    res.minute_out  = src.minute_in;
    res.second_out  = src.second_in;
    return res;
  endfunction

  // Compares one response beat against the oldest converted date.
  task automatic check_date(rsp_t got);
    rsp_t want;
    if (converted_dates.size() == 0) begin
      $error("response beat with no date pending: year_out %0d", got.year_out);
      mismatches++;
    end else begin
      want = converted_dates.pop_front();
      if (got.year_out !== want.year_out) begin
        $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
        mismatches++;
      end
      if (got.month_out !== want.month_out) begin
        $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
        mismatches++;
      end
      if (got.day_out !== want.day_out) begin
        $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
        mismatches++;
      end
      if (got.weekday_out !== want.weekday_out) begin
        $error("weekday_out: expected %0d, got %0d", want.weekday_out, got.weekday_out);
        mismatches++;
      end
      if (got.hour_out !== want.hour_out) begin
        $error("hour_out: expected %0d, got %0d", want.hour_out, got.hour_out);
        mismatches++;
      end
      if (got.minute_out !== want.minute_out) begin
        $error("minute_out: expected %0d, got %0d", want.minute_out, got.minute_out);
        mismatches++;
      end
      if (got.second_out !== want.second_out) begin
        $error("second_out: expected %0d, got %0d", want.second_out, got.second_out);
        mismatches++;
      end
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Response beats are checked before the request beat of the same edge is
  // queued; the block cannot answer a date in the cycle it takes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_date(rsp.data);
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        converted_dates.push_back(convert_date(req.data));
      end
      outstanding = converted_dates.size();
    end
  end

endmodule

FILE: verif/tb_gregorian_solar_hijri_convert_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_solar_hijri_convert_core
// Drives the date converter with directed corner dates and then random
// dates in both directions, under several idle and stall patterns, while
// a checker compares every converted date against its own computation.
// ----------------------------------------------------------------------------
module tb_gregorian_solar_hijri_convert_core
  import gshc_pkg::*;
;

  localparam int PHASE_DATES    = 125;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  int   idle_cycles;
  int   mismatches;
  int   outstanding;

  gshc_req_if req_ch ();
  gshc_rsp_if rsp_ch ();

  gregorian_solar_hijri_convert_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  gshc_date_checker date_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response side: ready is redrawn once per falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= (!rst && $urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_date(logic kind, int year, int month, int day,
                                     int weekday, int hour, int minute, int second);
    req_t d;
    d.kind       = kind;
    d.year_in    = year[11:0];
    d.month_in   = month[3:0];
    d.day_in     = day[4:0];
    d.weekday_in = weekday[2:0];
    d.hour_in    = hour[4:0];
    d.minute_in  = minute[5:0];
    d.second_in  = second[5:0];
    return d;
  endfunction

  // Mostly calendar-valid dates in the supported century, the rest raw bits.
  function automatic req_t random_date();
    req_t d;
    logic kind;
    kind = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      d = make_date(kind,
                    (kind == KIND_G2S) ? $urandom_range(2099, 2000)
                                       : $urandom_range(1478, 1378),
                    $urandom_range(12, 1), $urandom_range(31, 1), $urandom_range(6),
                    $urandom_range(23), $urandom_range(59), $urandom_range(59));
    end else begin
      d = req_t'($urandom());
      d.kind = kind;
    end
    return d;
  endfunction

  // Presents one beat, with random idle cycles ahead of it, and returns at
  // the falling edge after it is taken.
  task automatic send_date(req_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the request side quiet until every pending date has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    send_idle_pct = 0;
    stall_pct     = 0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed Gregorian to Shamsi: pass-through extremes, the day around
    // Nowruz, out-of-range month and day, and the widest year values.
    send_date(make_date(KIND_G2S, 2000, 1, 1, 0, 0, 0, 0));
    send_date(make_date(KIND_G2S, 2099, 12, 31, 7, 31, 63, 63));
    send_date(make_date(KIND_G2S, 2000, 3, 19, 1, 12, 30, 30));
    send_date(make_date(KIND_G2S, 2000, 3, 20, 2, 12, 30, 30));
    send_date(make_date(KIND_G2S, 2001, 3, 20, 3, 1, 2, 3));
    send_date(make_date(KIND_G2S, 2001, 3, 21, 4, 1, 2, 3));
    send_date(make_date(KIND_G2S, 2003, 7, 22, 5, 23, 59, 59));
    send_date(make_date(KIND_G2S, 0, 0, 0, 0, 0, 0, 0));
    send_date(make_date(KIND_G2S, 4095, 15, 31, 6, 16, 32, 32));
    send_date(make_date(KIND_G2S, 2002, 13, 5, 2, 8, 8, 8));
    send_date(make_date(KIND_G2S, 2078, 10, 31, 1, 2, 3, 4));

    // Directed Shamsi to Gregorian: the day around January 1, the year
    // wrap points at 21/22 and 78/79, and the same out-of-range inputs.
    send_date(make_date(KIND_S2G, 1378, 1, 1, 0, 0, 0, 0));
    send_date(make_date(KIND_S2G, 1399, 10, 11, 7, 31, 63, 63));
    send_date(make_date(KIND_S2G, 1399, 10, 12, 6, 0, 1, 2));
    send_date(make_date(KIND_S2G, 1400, 10, 10, 5, 3, 4, 5));
    send_date(make_date(KIND_S2G, 1400, 10, 11, 4, 3, 4, 5));
    send_date(make_date(KIND_S2G, 1421, 11, 1, 3, 10, 20, 30));
    send_date(make_date(KIND_S2G, 1422, 12, 30, 2, 11, 21, 31));
    send_date(make_date(KIND_S2G, 1478, 5, 9, 1, 12, 22, 32));
    send_date(make_date(KIND_S2G, 1479, 9, 31, 0, 13, 23, 33));
    send_date(make_date(KIND_S2G, 1402, 5, 9, 1, 14, 24, 34));
    send_date(make_date(KIND_S2G, 0, 0, 0, 0, 0, 0, 0));
    send_date(make_date(KIND_S2G, 4095, 15, 31, 7, 31, 63, 63));
    send_date(make_date(KIND_S2G, 1300, 14, 20, 3, 5, 6, 7));
    wait_drained();

    // Random dates: no idling, sender idle, receiver stalling, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_DATES; n++) send_date(random_date());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
